/* rtl/string_keyed_symbol_table_defines.svh */
// Assertion macros used by the checker file of the symbol table.
// Depends on nothing; macros need clock in scope, and all but the last need reset.
`ifndef STRING_KEYED_SYMBOL_TABLE_DEFINES_SVH
`define STRING_KEYED_SYMBOL_TABLE_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define SKST_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define SKST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define SKST_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/skst_pkg.sv */
// Package of the string keyed symbol table: sizes, codes and the stored entry layout.
// Depends on nothing; used by the top level and the checker.
`default_nettype none

package skst_pkg;

   // Default sizes of the table.
   localparam int TABLE_BYTES_DEFAULT = 1024;
   localparam int MAX_ENTRIES_DEFAULT = 512;

   // Longest name in bytes; a name is carried in two 64-bit words.
   localparam int NAME_BYTES = 16;

   // Bytes charged per entry on top of its name length.
   localparam int ENTRY_OVERHEAD = 2;

   // Command codes.
   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Status codes of a result.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // One stored entry, kept as a single memory word.
   typedef struct packed {
      logic [63:0] name_low;
      logic [63:0] name_high;
      logic [4:0]  name_length;
      logic [15:0] address;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

endpackage

`default_nettype wire

/* rtl/skst_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module skst_ram #(
   parameter int WIDTH      = 8,
   parameter int DEPTH      = 16,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/string_keyed_symbol_table.sv */
// Top level of the string keyed symbol table: controller, scan logic and entry memory.
// Depends on skst_pkg and skst_ram.
`default_nettype none

// Usage
// The req_ channel carries one command per transaction: add a name with a value, or
// look a name up. The rsp_ channel returns exactly one result per request, in order:
// the value and a status (ok, not found, or full when an add is rejected).
// Names are compared on their effective length and bytes; bytes beyond the length
// are ignored. Lookups return the earliest added matching entry.
// An add passes its result through the result register, then the output register.
// A lookup reads the entry memory one entry per cycle in insertion order, so a hit
// on a later entry takes longer, and a miss reads every entry before it is reported.
// The single read port of the entry memory sets this pace.
// Throughput: one request at a time; req_ready rises again once the result has
// been placed in the output register, so a new request can be taken while that
// result still waits for rsp_ready.
// Reset (synchronous, active high) empties the table and drops any pending result;
// the memory is not cleared. A stalled receiver holds the result, and the block
// waits for the slot to free before loading the next one.

module string_keyed_symbol_table #(
   parameter int TABLE_BYTES = skst_pkg::TABLE_BYTES_DEFAULT,
   parameter int MAX_ENTRIES = skst_pkg::MAX_ENTRIES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [63:0] req_key_low,
   input  wire logic [63:0] req_key_high,
   input  wire logic [4:0]  req_key_length,
   input  wire logic [15:0] req_entry_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [15:0] rsp_result_value,
   output logic      [1:0]  rsp_status
);

   import skst_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int BW = $clog2(TABLE_BYTES);
   localparam int SW = $clog2(TABLE_BYTES + NAME_BYTES + ENTRY_OVERHEAD + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_REPLY
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [BW-1:0] bytes_ff, bytes_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic        pend_ff, pend_in;
   logic [63:0] key_low_ff, key_low_in;
   logic [63:0] key_high_ff, key_high_in;
   logic [4:0]  key_len_ff, key_len_in;
   logic [15:0] res_value_ff, res_value_in;
   status_type  res_status_ff, res_status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_value_ff, rsp_value_in;
   status_type  rsp_status_ff, rsp_status_in;

   logic [4:0]  eff_len;
   logic [63:0] masked_low;
   logic [63:0] masked_high;
   logic [SW-1:0] bytes_after;
   logic        table_full;
   logic        issue_ok;
   logic        hit;
   logic        wr_en;
   logic        rd_en;
   entry_type   wr_entry;
   entry_type   rd_entry;
   logic [ENTRY_WIDTH-1:0] rd_word;

   // Effective name length: zero counts as one, longer names saturate.
   always_comb begin
      if (req_key_length == 5'd0) begin
         eff_len = 5'd1;
      end else if (req_key_length > 5'(NAME_BYTES)) begin
         eff_len = 5'(NAME_BYTES);
      end else begin
         eff_len = req_key_length;
      end
   end

   // Clear the name bytes at and above the effective length.
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         masked_low[8*b +: 8]  = (5'(b) < eff_len) ? req_key_low[8*b +: 8] : 8'h00;
         masked_high[8*b +: 8] = (5'(b + 8) < eff_len) ? req_key_high[8*b +: 8] : 8'h00;
      end
   end

   // Budget check for an add.
   assign bytes_after = SW'(bytes_ff) + SW'(eff_len) + SW'(ENTRY_OVERHEAD);
   assign table_full  = (count_ff == CW'(MAX_ENTRIES)) || (bytes_after >= SW'(TABLE_BYTES));

   // Scan progress and comparison of the entry read in the previous cycle.
   assign issue_ok = idx_ff < count_ff;
   assign rd_entry = entry_type'(rd_word);
   assign hit      = (rd_entry.name_length == key_len_ff) &&
                     (rd_entry.name_low == key_low_ff) &&
                     (rd_entry.name_high == key_high_ff);

   assign wr_entry.name_low    = masked_low;
   assign wr_entry.name_high   = masked_high;
   assign wr_entry.name_length = eff_len;
   assign wr_entry.address     = req_entry_value;

   // Entry memory.
   skst_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_word)
   );

   // Next-state logic of the controller.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      bytes_in      = bytes_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      key_low_in    = key_low_ff;
      key_high_in   = key_high_ff;
      key_len_in    = key_len_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_ADD) begin
                  if (table_full) begin
                     res_value_in  = 16'd0;
                     res_status_in = ST_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     count_in      = count_ff + CW'(1);
                     bytes_in      = bytes_after[BW-1:0];
                     res_value_in  = req_entry_value;
                     res_status_in = ST_OK;
                  end
                  state_in = S_REPLY;
               end else begin
                  key_low_in  = masked_low;
                  key_high_in = masked_high;
                  key_len_in  = eff_len;
                  idx_in      = '0;
                  pend_in     = 1'b0;
                  state_in    = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (pend_ff && hit) begin
               res_value_in  = rd_entry.address;
               res_status_in = ST_OK;
               state_in      = S_REPLY;
            end else if (!issue_ok) begin
               res_value_in  = 16'd0;
               res_status_in = ST_NOT_FOUND;
               state_in      = S_REPLY;
            end else begin
               rd_en   = 1'b1;
               idx_in  = idx_ff + CW'(1);
               pend_in = 1'b1;
            end
         end
         S_REPLY: begin
            // Load the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         bytes_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         bytes_ff     <= bytes_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      key_low_ff    <= key_low_in;
      key_high_ff   <= key_high_in;
      key_len_ff    <= key_len_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

`default_nettype wire

/* rtl/skst_checker.sv */
// Port-level checker of the string keyed symbol table, bound to the top level.
// Depends on skst_pkg and string_keyed_symbol_table_defines.svh.
`default_nettype none

`include "string_keyed_symbol_table_defines.svh"

module skst_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_result_value,
   input wire logic [1:0]  rsp_status
);

   import skst_pkg::*;

   // Only one request is in flight, so acceptance drops ready in the following cycle.
   `SKST_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")

   // Misses and rejected adds always carry a zero value.
   `SKST_ASSERT_NOW(a_zero_on_fail, rsp_valid && (rsp_status != ST_OK), rsp_result_value == 16'd0, "non-zero value on failure")

   // A stalled result holds steady.
   `SKST_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value) && $stable(rsp_status), "stalled result changed")

   // Reset drops any pending result.
   `SKST_ASSERT_ALWAYS(a_reset_clears, reset, !rsp_valid, "result valid after reset")

endmodule

bind string_keyed_symbol_table skst_checker u_skst_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value),
   .rsp_status       (rsp_status)
);

`default_nettype wire
